// File: rtl/dsivf_pkg.sv
// Shared constants and types for the dual-sensor inverse-variance fusion block.
package dsivf_pkg;

  // Default number of axes per sensor
  localparam int unsigned AxesDef = 3;

  // Field widths
  localparam int unsigned SampleW = 32;  // signed Q16.16 rate sample
  localparam int unsigned GainW   = 16;  // unsigned Q0.16 smoothing gain
  localparam int unsigned FloorW  = 32;  // unsigned Q16.16 variance floor
  localparam int unsigned SpreadW = 48;  // unsigned Q32.16 running variance

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGain  = 2'd0,
    CfgFloor = 2'd1
  } cfg_idx_e;

  localparam logic [GainW-1:0]  GainReset  = 16'd3277;
  localparam logic [FloorW-1:0] FloorReset = 32'd66;

  // Shared multiplier: unsigned operands, full product
  localparam int unsigned MulW  = 32;
  localparam int unsigned ProdW = 2 * MulW;

  // Accumulator for split products: a 48 x 32 bit product
  localparam int unsigned AccW = SpreadW + SampleW;

  // Divider: numerator magnitude, denominator, quotient
  localparam int unsigned DivNumW = AccW;
  localparam int unsigned DenW    = SpreadW + 1;
  localparam int unsigned QuotW   = SampleW;

endpackage

// File: rtl/dsivf_mul.sv
// Shared 32 x 32 unsigned multiplier with a registered product.
module dsivf_mul (
  input  logic                        clk_i,
  input  logic [dsivf_pkg::MulW-1:0]  a_i,
  input  logic [dsivf_pkg::MulW-1:0]  b_i,
  output logic [dsivf_pkg::ProdW-1:0] prod_o
);
  import dsivf_pkg::*;

  logic [ProdW-1:0] prod_d, prod_q;

  // Full-width unsigned product
  assign prod_d = ProdW'(a_i) * ProdW'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/dsivf_div.sv
// Restoring divider, one quotient bit per cycle, for the fused-rate quotient.
module dsivf_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dsivf_pkg::DivNumW-1:0] dividend_i,
  input  logic [dsivf_pkg::DenW-1:0]    divisor_i,
  output logic                          done_o,
  output logic [dsivf_pkg::QuotW-1:0]   quot_o
);
  import dsivf_pkg::*;

  localparam int unsigned CntW = $clog2(QuotW + 1);

  logic             busy_d, busy_q;
  logic [CntW-1:0]  cnt_d, cnt_q;
  logic [DenW-1:0]  dvs_d, dvs_q;
  logic [DenW-1:0]  rem_d, rem_q;
  logic [QuotW-1:0] lo_d, lo_q;
  logic [DenW:0]    trial;
  logic [DenW:0]    trial_sub;
  logic             ge;

  // One restoring step: shift in the next numerator bit, try the subtract
  assign trial     = {rem_q, lo_q[QuotW-1]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign ge        = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    if (start_i) begin
      // The high part of the numerator is already below the divisor
      busy_d = 1'b1;
      cnt_d  = CntW'(QuotW);
      dvs_d  = divisor_i;
      rem_d  = DenW'(dividend_i[DivNumW-1:QuotW]);
      lo_d   = dividend_i[QuotW-1:0];
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - 1'b1;
        rem_d = ge ? trial_sub[DenW-1:0] : trial[DenW-1:0];
        lo_d  = {lo_q[QuotW-2:0], ge};
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    lo_q  <= lo_d;
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = lo_q;

endmodule

// File: rtl/dual_sensor_inverse_variance_fusion.sv
// Sequencing: per axis, the first and then the second sensor update run on the shared multiplier,
// then the fusion setup forms numerator and denominator and the 32-step divider runs; an axis whose
// two variances are both zero skips the divider. Only one item is in flight: input is taken only in
// idle, once the previous result has entered the output register, so a new item is taken while the
// previous result waits downstream.
// Reset: means clear to zero, variances load the reset floor (66), gain and floor registers
module dual_sensor_inverse_variance_fusion #(
  parameter int unsigned AXES = dsivf_pkg::AxesDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // first_* per axis from bit 0 up, then second_* per axis
  input  logic [2*AXES*dsivf_pkg::SampleW-1:0]   s_axis_tdata,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // fused_* per axis from bit 0 up
  output logic [AXES*dsivf_pkg::SampleW-1:0]     m_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [dsivf_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [dsivf_pkg::CfgDataW-1:0]         cfg_data_i
);
  // load their reset values; no clearing pass.
  import dsivf_pkg::*;

  localparam int unsigned AxW   = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int unsigned NumSt = 23;

  typedef enum logic [NumSt-1:0] {
    StIdle     = (23'd1 << 0),
    StLoad     = (23'd1 << 1),
    StDiff     = (23'd1 << 2),
    StGainMag  = (23'd1 << 3),
    StSquare   = (23'd1 << 4),
    StSqLo     = (23'd1 << 5),
    StSqHi     = (23'd1 << 6),
    StSqSum    = (23'd1 << 7),
    StSpread   = (23'd1 << 8),
    StDecLo    = (23'd1 << 9),
    StDecHi    = (23'd1 << 10),
    StDecSum   = (23'd1 << 11),
    StStore    = (23'd1 << 12),
    StFuseAbs  = (23'd1 << 13),
    StPaLo     = (23'd1 << 14),
    StPaHi     = (23'd1 << 15),
    StPbLo     = (23'd1 << 16),
    StPbHi     = (23'd1 << 17),
    StPbSum    = (23'd1 << 18),
    StNumSum   = (23'd1 << 19),
    StDivStart = (23'd1 << 20),
    StDivWait  = (23'd1 << 21),
    StDone     = (23'd1 << 22)
  } state_e;

  // Control state
  state_e              state_d, state_q;
  logic [AxW-1:0]      ax_d, ax_q;
  logic                sel_d, sel_q;
  logic                out_valid_d, out_valid_q;
  logic [GainW-1:0]    gain_d, gain_q;
  logic [FloorW-1:0]   floor_d, floor_q;
  logic [SampleW-1:0]  mean_d   [2][AXES];
  logic [SampleW-1:0]  mean_q   [2][AXES];
  logic [SpreadW-1:0]  spread_d [2][AXES];
  logic [SpreadW-1:0]  spread_q [2][AXES];

  // Working registers
  logic [2*AXES*SampleW-1:0] in_d, in_q;
  logic [SampleW-1:0]        v_d, v_q;
  logic [SampleW-1:0]        m_d, m_q;
  logic [SpreadW-1:0]        var_d, var_q;
  logic                      neg_d, neg_q;
  logic [SampleW-1:0]        mag_d, mag_q;
  logic [15:0]               sqh_d, sqh_q;
  logic [AccW-1:0]           acc_d, acc_q;
  logic [SpreadW-1:0]        s_d, s_q;
  logic                      sgn1_d, sgn1_q, sgn2_d, sgn2_q;
  logic [SampleW-1:0]        mag1_d, mag1_q, mag2_d, mag2_q;
  logic [DenW-1:0]           den_d, den_q;
  logic [AccW:0]             num_d, num_q;
  logic                      nneg_d, nneg_q;
  logic [AXES*SampleW-1:0]   fused_d, fused_q;
  logic [AXES*SampleW-1:0]   out_d, out_q;

  // Shared unit connections
  logic [MulW-1:0]    mul_a, mul_b;
  logic [ProdW-1:0]   prod;
  logic               div_start, div_done;
  logic [DivNumW-1:0] div_num;
  logic [QuotW-1:0]   quot;

  // Datapath helpers
  logic [SampleW-1:0]  first_w  [AXES];
  logic [SampleW-1:0]  second_w [AXES];
  logic [SampleW:0]    diff, diff_neg;
  logic [SpreadW:0]    prod_ext, pm;
  logic [AccW-1:0]     acc_shift_sum;
  logic [SpreadW:0]    s_sum;
  logic [SpreadW-1:0]  r_dec, var_new, floor_ext;
  logic [GainW:0]      dec_gain;
  logic [SampleW-1:0]  v1_neg, v2_neg;
  logic [AccW:0]       acc_ext, num_abs;
  logic [QuotW-1:0]    quot_neg;

  dsivf_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  dsivf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Unpack the held input item per sensor and axis
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      first_w[i]  = in_q[i*SampleW +: SampleW];
      second_w[i] = in_q[(AXES+i)*SampleW +: SampleW];
    end
  end

  // Statistics arithmetic
  assign diff          = {v_q[SampleW-1], v_q} - {m_q[SampleW-1], m_q};
  assign diff_neg      = -diff;
  assign prod_ext      = {1'b0, prod[SpreadW-1:0]};
  assign pm            = neg_q ? -prod_ext : prod_ext;
  assign acc_shift_sum = acc_q + {prod[SpreadW-1:0], 32'b0};
  assign s_sum         = {1'b0, var_q} + {1'b0, acc_q[63:16]};
  assign r_dec         = acc_q[63:16];
  assign floor_ext     = SpreadW'(floor_q);
  assign var_new       = (r_dec < floor_ext) ? floor_ext : r_dec;
  assign dec_gain      = 17'h10000 - {1'b0, gain_q};

  // Fusion arithmetic
  assign v1_neg   = -first_w[ax_q];
  assign v2_neg   = -second_w[ax_q];
  assign acc_ext  = {1'b0, acc_q};
  assign num_abs  = num_q[AccW] ? -num_q : num_q;
  assign div_num  = num_abs[DivNumW-1:0];
  assign quot_neg = -quot;

  // Sequencer and datapath next values
  always_comb begin
    state_d     = state_q;
    ax_d        = ax_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    gain_d      = gain_q;
    floor_d     = floor_q;
    mean_d      = mean_q;
    spread_d    = spread_q;
    in_d        = in_q;
    v_d         = v_q;
    m_d         = m_q;
    var_d       = var_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    sqh_d       = sqh_q;
    acc_d       = acc_q;
    s_d         = s_q;
    sgn1_d      = sgn1_q;
    sgn2_d      = sgn2_q;
    mag1_d      = mag1_q;
    mag2_d      = mag2_q;
    den_d       = den_q;
    num_d       = num_q;
    nneg_d      = nneg_q;
    fused_d     = fused_q;
    out_d       = out_q;
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;

    // Register writes
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgGain:  gain_d  = cfg_data_i[GainW-1:0];
        CfgFloor: floor_d = cfg_data_i[FloorW-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          in_d    = s_axis_tdata;
          ax_d    = '0;
          sel_d   = 1'b0;
          state_d = StLoad;
        end
      end
      // Fetch sample and statistics of the current sensor and axis
      StLoad: begin
        v_d     = sel_q ? second_w[ax_q] : first_w[ax_q];
        m_d     = mean_q[sel_q][ax_q];
        var_d   = spread_q[sel_q][ax_q];
        state_d = StDiff;
      end
      StDiff: begin
        neg_d   = diff[SampleW];
        mag_d   = diff[SampleW] ? diff_neg[SampleW-1:0] : diff[SampleW-1:0];
        state_d = StGainMag;
      end
      StGainMag: begin
        mul_a   = MulW'(gain_q);
        mul_b   = mag_q;
        state_d = StSquare;
      end
      // Mean step: floor of signed g*diff over 2^16
      StSquare: begin
        mul_a   = mag_q;
        mul_b   = mag_q;
        m_d     = m_q + pm[SampleW+15:16];
        state_d = StSqLo;
      end
      // sq = diff^2 / 2^16, then g*sq in two partial products
      StSqLo: begin
        sqh_d   = prod[63:48];
        mul_a   = MulW'(gain_q);
        mul_b   = prod[47:16];
        state_d = StSqHi;
      end
      StSqHi: begin
        mul_a   = MulW'(gain_q);
        mul_b   = MulW'(sqh_q);
        acc_d   = AccW'(prod);
        state_d = StSqSum;
      end
      StSqSum: begin
        acc_d   = acc_shift_sum;
        state_d = StSpread;
      end
      // Add the scaled square, saturate at the variance range
      StSpread: begin
        s_d     = s_sum[SpreadW] ? '1 : s_sum[SpreadW-1:0];
        state_d = StDecLo;
      end
      // Decay by (1 - g) in two partial products
      StDecLo: begin
        mul_a   = MulW'(dec_gain);
        mul_b   = s_q[31:0];
        state_d = StDecHi;
      end
      StDecHi: begin
        mul_a   = MulW'(dec_gain);
        mul_b   = MulW'(s_q[47:32]);
        acc_d   = AccW'(prod);
        state_d = StDecSum;
      end
      StDecSum: begin
        acc_d   = acc_shift_sum;
        state_d = StStore;
      end
      StStore: begin
        mean_d[sel_q][ax_q]   = m_q;
        spread_d[sel_q][ax_q] = var_new;
        if (!sel_q) begin
          sel_d   = 1'b1;
          state_d = StLoad;
        end else begin
          sel_d   = 1'b0;
          state_d = StFuseAbs;
        end
      end
      // Fusion: sign/magnitude split and the denominator
      StFuseAbs: begin
        sgn1_d  = first_w[ax_q][SampleW-1];
        sgn2_d  = second_w[ax_q][SampleW-1];
        mag1_d  = first_w[ax_q][SampleW-1] ? v1_neg : first_w[ax_q];
        mag2_d  = second_w[ax_q][SampleW-1] ? v2_neg : second_w[ax_q];
        den_d   = {1'b0, spread_q[0][ax_q]} + {1'b0, spread_q[1][ax_q]};
        state_d = StPaLo;
      end
      // var2 * |v1|
      StPaLo: begin
        mul_a   = spread_q[1][ax_q][31:0];
        mul_b   = mag1_q;
        state_d = StPaHi;
      end
      StPaHi: begin
        mul_a   = MulW'(spread_q[1][ax_q][47:32]);
        mul_b   = mag1_q;
        acc_d   = AccW'(prod);
        state_d = StPbLo;
      end
      // var1 * |v2|
      StPbLo: begin
        mul_a   = spread_q[0][ax_q][31:0];
        mul_b   = mag2_q;
        acc_d   = acc_shift_sum;
        state_d = StPbHi;
      end
      StPbHi: begin
        mul_a   = MulW'(spread_q[0][ax_q][47:32]);
        mul_b   = mag2_q;
        num_d   = sgn1_q ? ('0 - acc_ext) : acc_ext;
        acc_d   = AccW'(prod);
        state_d = StPbSum;
      end
      StPbSum: begin
        acc_d   = acc_shift_sum;
        state_d = StNumSum;
      end
      StNumSum: begin
        num_d   = sgn2_q ? (num_q - acc_ext) : (num_q + acc_ext);
        state_d = StDivStart;
      end
      // Zero denominator passes the first sensor's sample
      StDivStart: begin
        nneg_d = num_q[AccW];
        if (den_q == '0) begin
          fused_d[ax_q*SampleW +: SampleW] = first_w[ax_q];
          if (ax_q == AxW'(AXES - 1)) begin
            state_d = StDone;
          end else begin
            ax_d    = ax_q + 1'b1;
            state_d = StLoad;
          end
        end else begin
          div_start = 1'b1;
          state_d   = StDivWait;
        end
      end
      StDivWait: begin
        if (div_done) begin
          fused_d[ax_q*SampleW +: SampleW] = nneg_q ? quot_neg : quot;
          if (ax_q == AxW'(AXES - 1)) begin
            state_d = StDone;
          end else begin
            ax_d    = ax_q + 1'b1;
            state_d = StLoad;
          end
        end
      end
      // Hand the item to the output register once it is free
      StDone: begin
        if (!out_valid_q || m_axis_tready) begin
          out_d       = fused_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ax_q        <= '0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
      gain_q      <= GainReset;
      floor_q     <= FloorReset;
      for (int k = 0; k < 2; k++) begin
        for (int i = 0; i < AXES; i++) begin
          mean_q[k][i]   <= '0;
          spread_q[k][i] <= SpreadW'(FloorReset);
        end
      end
    end else begin
      state_q     <= state_d;
      ax_q        <= ax_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
      gain_q      <= gain_d;
      floor_q     <= floor_d;
      mean_q      <= mean_d;
      spread_q    <= spread_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    v_q     <= v_d;
    m_q     <= m_d;
    var_q   <= var_d;
    neg_q   <= neg_d;
    mag_q   <= mag_d;
    sqh_q   <= sqh_d;
    acc_q   <= acc_d;
    s_q     <= s_d;
    sgn1_q  <= sgn1_d;
    sgn2_q  <= sgn2_d;
    mag1_q  <= mag1_d;
    mag2_q  <= mag2_d;
    den_q   <= den_d;
    num_q   <= num_d;
    nneg_q  <= nneg_d;
    fused_q <= fused_d;
    out_q   <= out_d;
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign cfg_ready_o   = 1'b1;

endmodule

// File: verif/dual_sensor_inverse_variance_fusion_test.sv
// Self-checking testbench for the dual-sensor inverse-variance fusion block.
module dual_sensor_inverse_variance_fusion_test;
  import dsivf_pkg::*;

  localparam int unsigned Axes = AxesDef;
  localparam int SettleCycles = 250;

  // register indices the block does not decode; writes to them are dropped
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  localparam logic [SampleW-1:0] RateMax = 32'h7fff_ffff;
  localparam logic [SampleW-1:0] RateMin = 32'h8000_0000;
  localparam logic [SpreadW-1:0] SpreadMax = '1;

  // one rate per axis, x in the lowest bits
  typedef logic [Axes-1:0][SampleW-1:0] rate_vec_t;
  // packs as {second, first}, so first_x sits at bit 0
  typedef struct packed {
    rate_vec_t second;
    rate_vec_t first;
  } sample_pair_t;

  localparam rate_vec_t AllMax  = {Axes{RateMax}};
  localparam rate_vec_t AllMin  = {Axes{RateMin}};
  localparam rate_vec_t AllZero = '0;

  string fused_name [Axes] = '{"fused_x", "fused_y", "fused_z"};

  logic         clk_i  = 1'b0;
  logic         rst_ni = 1'b0;
  sample_pair_t s_axis_tdata  = '0;   // first_x, first_y, first_z, second_x, second_y, second_z
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  rate_vec_t    m_axis_tdata;         // fused_x, fused_y, fused_z
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  dual_sensor_inverse_variance_fusion #(
    .AXES(Axes)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Expected block state: registers plus per-sensor, per-axis mean and variance
  logic [GainW-1:0]          gain_q;
  logic [FloorW-1:0]         floor_q;
  logic signed [SampleW-1:0] mean_q   [2][Axes];
  logic [SpreadW-1:0]        spread_q [2][Axes];

  sample_pair_t pending_q [$];
  rate_vec_t    fused_expect_q [$];

  int unsigned samples_taken   = 0;
  int unsigned results_checked = 0;
  int unsigned issued          = 0;
  int unsigned results_seen    = 0;
  int unsigned cfg_writes      = 0;
  int unsigned mismatches      = 0;
  int          send_wait       = 0;
  int          sink_wait       = 0;
  logic        idle_on         = 1'b1;

  // Running mean and variance update of one sensor on one axis
  function automatic void track_sensor(int sensor, int a, logic signed [SampleW-1:0] rate);
    logic signed [127:0] diff, gain_w, acc;
    gain_w = {112'b0, gain_q};
    diff   = rate;
    acc    = mean_q[sensor][a];
    diff   = diff - acc;
    acc    = (gain_w * diff) >>> 16;      // floor of g*diff
    acc    = acc + mean_q[sensor][a];
    mean_q[sensor][a] = acc[SampleW-1:0];
    acc = (diff * diff) >>> 16;
    acc = spread_q[sensor][a] + ((gain_w * acc) >>> 16);
    if (acc > SpreadMax) acc = SpreadMax;
    acc = ((128'sd65536 - gain_w) * acc) >>> 16;
    if (acc < floor_q) acc = floor_q;
    spread_q[sensor][a] = acc[SpreadW-1:0];
  endfunction

  // Updates both sensors, then weights each by the other's variance
  function automatic rate_vec_t predict_fused(sample_pair_t smp);
    rate_vec_t fused;
    logic signed [127:0] num, den, w_first, w_second;
    for (int a = 0; a < Axes; a++) begin
      track_sensor(0, a, smp.first[a]);
      track_sensor(1, a, smp.second[a]);
      den      = spread_q[0][a] + spread_q[1][a];
      w_first  = $signed(smp.first[a]);
      w_second = $signed(smp.second[a]);
      if (den == 0) begin
        fused[a] = smp.first[a];
      end else begin
        num = w_first * $signed({80'b0, spread_q[1][a]})
            + w_second * $signed({80'b0, spread_q[0][a]});
        fused[a] = num / den;                // signed divide truncates toward zero
      end
    end
    return fused;
  endfunction

  function automatic logic [SampleW-1:0] extreme_rate();
    case ($urandom_range(0, 3))
      0: return RateMax;
      1: return RateMin;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // Acceptance and result check
  always @(posedge clk_i) begin
    rate_vec_t want;
    if (s_axis_tvalid && s_axis_tready) begin
      fused_expect_q.push_back(predict_fused(s_axis_tdata));
      samples_taken++;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      results_checked++;
      if (fused_expect_q.size() == 0) begin
        $error("fused item with nothing expected: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = fused_expect_q.pop_front();
        for (int a = 0; a < Axes; a++) begin
          if (m_axis_tdata[a] !== want[a]) begin
            $error("%s mismatch: expected %0d, got %0d", fused_name[a],
                   $signed(want[a]), $signed(m_axis_tdata[a]));
            mismatches++;
          end
        end
      end
    end
  end

  // Sample driver: holds an item until taken, then waits its drawn gap
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || samples_taken == issued)) begin
      if (send_wait > 0) begin
        s_axis_tvalid <= 1'b0;
        // gap counts only while the block could take an item
        if (s_axis_tready || fused_expect_q.size() == 0) send_wait--;
      end else if (pending_q.size() > 0) begin
        s_axis_tdata  <= pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        issued++;
        send_wait = idle_on ? $urandom_range(0, 3) : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result sink: stall cycles count only while a result is offered
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (results_checked != results_seen) begin
        results_seen = results_checked;
        sink_wait    = idle_on ? $urandom_range(0, 3) : 0;
      end
      if (sink_wait > 0) begin
        m_axis_tready <= 1'b0;
        if (m_axis_tvalid) sink_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgGain:  gain_q  = value[GainW-1:0];
      CfgFloor: floor_q = value[FloorW-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Sender pauses until every queued item is taken and every result is back
  task automatic drain();
    while (pending_q.size() != 0 || issued != samples_taken || fused_expect_q.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    logic [SampleW-1:0] base [Axes];
    int unsigned        amp_first, amp_second, kind;
    sample_pair_t       smp;
    rate_vec_t          steady_first, steady_second;

    gain_q  = GainReset;
    floor_q = FloorReset;
    for (int a = 0; a < Axes; a++) begin
      mean_q[0][a]   = '0;
      mean_q[1][a]   = '0;
      spread_q[0][a] = FloorReset;
      spread_q[1][a] = FloorReset;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: zeros, full-scale rates, opposing extremes
    @(posedge clk_i);
    pending_q.push_back({AllZero, AllZero});
    pending_q.push_back({AllMax, AllMax});
    pending_q.push_back({AllMin, AllMin});
    pending_q.push_back({AllMin, AllMax});
    pending_q.push_back({rate_vec_t'({32'd1, 32'hffff_ffff, RateMin}),
                         rate_vec_t'({32'hffff_ffff, 32'd1, RateMax})});
    drain();

    // Unused indices are ignored; zero gain freezes the mean, floor at its top
    write_reg(CfgSpareLo, 32'hdead_beef);
    write_reg(CfgSpareHi, 32'h0000_0001);
    write_reg(CfgGain, '0);
    write_reg(CfgFloor, '1);
    @(posedge clk_i);
    pending_q.push_back({AllMax, AllMin});
    pending_q.push_back({AllZero, AllMax});
    pending_q.push_back({rate_vec_t'({RateMax, 32'd0, RateMin}),
                         rate_vec_t'({32'd5, RateMin, 32'hffff_fff0})});
    drain();

    // Full gain, zero floor: large swings, then a steady input lets both
    // variances decay to zero so the fused rate falls back to the first sensor
    write_reg(CfgGain, '1);
    write_reg(CfgFloor, '0);
    @(posedge clk_i);
    steady_first  = {32'd1000, 32'hffff_fffb, RateMax};
    steady_second = {32'hffff_f830, 32'd7, RateMin};
    pending_q.push_back({AllMin, AllMax});
    pending_q.push_back({AllMax, AllMin});
    pending_q.push_back({AllMin, AllMax});
    pending_q.push_back({AllMax, AllMin});
    repeat (7) pending_q.push_back({steady_second, steady_first});
    drain();

    // Smallest nonzero gain and floor
    write_reg(CfgGain, 32'd1);
    write_reg(CfgFloor, 32'd1);
    @(posedge clk_i);
    repeat (3) begin
      for (int a = 0; a < Axes; a++) begin
        smp.first[a]  = extreme_rate();
        smp.second[a] = extreme_rate();
      end
      pending_q.push_back(smp);
    end

    // Random phases: noisy rates around a drifting base, some wild items
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case ($urandom_range(0, 5))
        0: write_reg(CfgGain, 32'h0000_ffff);
        1: write_reg(CfgGain, 32'd1);
        2: write_reg(CfgGain, GainReset);
        3: write_reg(CfgGain, '0);
        default: write_reg(CfgGain, $urandom_range(1, 16'hffff));
      endcase
      case ($urandom_range(0, 4))
        0: write_reg(CfgFloor, '1);
        1: write_reg(CfgFloor, '0);
        2: write_reg(CfgFloor, FloorReset);
        3: write_reg(CfgFloor, $urandom());
        default: write_reg(CfgFloor, $urandom_range(1, 1 << 20));
      endcase
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? CfgSpareLo : CfgSpareHi, $urandom());
      @(posedge clk_i);
      idle_on    = (ph % 3 != 1);
      amp_first  = 1 << $urandom_range(0, 20);
      amp_second = 1 << $urandom_range(0, 20);
      for (int a = 0; a < Axes; a++)
        base[a] = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      for (int n = 0; n < 80; n++) begin
        if (n == 40 && ph % 2 == 0) begin
          drain();
          @(posedge clk_i);
        end
        kind = $urandom_range(0, 9);
        for (int a = 0; a < Axes; a++) begin
          case (kind)
            0: begin
              smp.first[a]  = $urandom();
              smp.second[a] = $urandom();
            end
            1: begin
              smp.first[a]  = extreme_rate();
              smp.second[a] = extreme_rate();
            end
            default: begin
              smp.first[a]  = base[a] + $urandom_range(0, 2 * amp_first) - amp_first;
              smp.second[a] = base[a] + $urandom_range(0, 2 * amp_second) - amp_second;
            end
          endcase
        end
        pending_q.push_back(smp);
      end
    end

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (fused_expect_q.size() != 0) begin
      $error("%0d fused items never arrived", fused_expect_q.size());
      mismatches++;
    end
    $display("Checked %0d fused items from %0d samples across %0d register writes.",
             results_checked, samples_taken, cfg_writes);
    $display("Gain and floor swept over zero, minimum, default and full scale.");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
